// ----- rtl/core/lkht_pkg.sv -----
package lkht_pkg;

    localparam int KEY_W = 16;
    localparam int KEY_PORTS = 8;
    localparam int KEY_LENGTH_W = 4;
    localparam logic [KEY_LENGTH_W-1:0] KEY_LENGTH_RESET = 4'd5;

    localparam logic [63:0] HASH_MUL = 64'd1664525;

    // Slot generation tag width; a full sweep of the slot memory follows every
    // wrap of the tag.
    localparam int EPOCH_W = 4;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_CLEAR  = 2'd2
    } command_t;

    typedef enum logic [2:0] {
        ST_FOUND    = 3'd0,
        ST_INSERTED = 3'd1,
        ST_ABSENT   = 3'd2,
        ST_FULL     = 3'd3,
        ST_CLEARED  = 3'd4
    } status_t;

endpackage

// ----- rtl/core/lattice_key_hash_table.sv -----
// Open-addressing hash table with linear probing that gives each key of up to
// KEY_MAX signed 16-bit coordinates a dense id in insertion order. One input
// beat carries a command and a key, and each input beat gives exactly one
// output beat. A lookup or insert hashes the n key coordinates in use, one
// at a time through a single shared multiplier, then reads the home slot from
// the slot memory. Every occupied slot whose key does not match adds a key
// read from the per-coordinate key memories and then a read of the next slot,
// and a match adds a key read. A clear goes straight to the done state. After
// every fifteenth clear, and after reset, the block sweeps the slot memory at
// one slot per cycle and takes no beat meanwhile. Inserts are refused with
// status full once the table holds SLOT_COUNT/2 entries. key_length may only
// be written while the block is idle.
module lattice_key_hash_table #(
    parameter int SLOT_COUNT = 1024,
    parameter int KEY_MAX = 8,
    localparam int HW = $clog2(SLOT_COUNT),
    localparam int ID_W = HW - 1,
    localparam int CNT_W = HW
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [1:0]                              command,
    input  logic signed [lkht_pkg::KEY_W-1:0]       key_0,
    input  logic signed [lkht_pkg::KEY_W-1:0]       key_1,
    input  logic signed [lkht_pkg::KEY_W-1:0]       key_2,
    input  logic signed [lkht_pkg::KEY_W-1:0]       key_3,
    input  logic signed [lkht_pkg::KEY_W-1:0]       key_4,
    input  logic signed [lkht_pkg::KEY_W-1:0]       key_5,
    input  logic signed [lkht_pkg::KEY_W-1:0]       key_6,
    input  logic signed [lkht_pkg::KEY_W-1:0]       key_7,
    input  logic                                    cfg_wr_en,
    input  logic [lkht_pkg::KEY_LENGTH_W-1:0]       cfg_wr_data,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [ID_W-1:0]                         entry_id,
    output logic [2:0]                              status,
    output logic [CNT_W-1:0]                        entry_count
);

    localparam int CAP = SLOT_COUNT / 2;
    localparam int N_W = $clog2(KEY_MAX + 1);
    localparam int LANE_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int SLOT_W = lkht_pkg::EPOCH_W + ID_W;
    localparam logic [HW-1:0] HASH_MUL_C = HW'(lkht_pkg::HASH_MUL);
    localparam logic [lkht_pkg::EPOCH_W-1:0] EPOCH_FIRST = lkht_pkg::EPOCH_W'(1);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_KEY_CHK,
        S_DONE
    } state_t;

    state_t                               state_reg, state_next;
    logic [lkht_pkg::KEY_LENGTH_W-1:0]    key_length_reg, key_length_next;
    logic [CNT_W-1:0]                     fill_reg, fill_next;
    logic [lkht_pkg::EPOCH_W-1:0]         epoch_reg, epoch_next;
    logic [HW-1:0]                        sweep_reg, sweep_next;
    logic                                 sweep_pending_reg, sweep_pending_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [ID_W-1:0]                      entry_id_reg, entry_id_next;
    lkht_pkg::status_t                    status_reg, status_next;
    logic [CNT_W-1:0]                     entry_count_reg, entry_count_next;

    logic                                 ins_reg, ins_next;
    logic [lkht_pkg::KEY_W-1:0]           key_reg [KEY_MAX];
    logic [lkht_pkg::KEY_W-1:0]           key_next [KEY_MAX];
    logic [N_W-1:0]                       n_reg, n_next;
    logic [N_W-1:0]                       idx_reg, idx_next;
    logic [HW-1:0]                        hash_reg, hash_next;
    logic [HW-1:0]                        probe_reg, probe_next;
    logic [ID_W-1:0]                      entry_reg, entry_next;
    logic [ID_W-1:0]                      res_id_reg, res_id_next;
    lkht_pkg::status_t                    res_status_reg, res_status_next;

    logic [lkht_pkg::KEY_W-1:0]           key_in [lkht_pkg::KEY_PORTS];
    logic [lkht_pkg::KEY_W-1:0]           key_rd [KEY_MAX];
    logic [KEY_MAX-1:0]                   lane_we;
    logic [N_W-1:0]                       len_used;
    logic [lkht_pkg::KEY_W-1:0]           lane_sel;
    logic [HW-1:0]                        hash_sum;
    logic [HW-1:0]                        hash_prod;
    logic                                 slot_we;
    logic [HW-1:0]                        slot_wr_addr;
    logic [SLOT_W-1:0]                    slot_wr_data;
    logic [HW-1:0]                        slot_rd_addr;
    logic [SLOT_W-1:0]                    slot_rd_data;
    logic [lkht_pkg::EPOCH_W-1:0]         slot_epoch;
    logic [ID_W-1:0]                      slot_id;
    logic                                 slot_hit;
    logic                                 key_match;
    logic                                 table_full;
    logic                                 insert_now;

    assign key_in[0] = key_0;
    assign key_in[1] = key_1;
    assign key_in[2] = key_2;
    assign key_in[3] = key_3;
    assign key_in[4] = key_4;
    assign key_in[5] = key_5;
    assign key_in[6] = key_6;
    assign key_in[7] = key_7;

    always_comb
    begin
        if (key_length_reg == '0)
        begin
            len_used = N_W'(1);
        end
        else if (key_length_reg > lkht_pkg::KEY_LENGTH_W'(KEY_MAX))
        begin
            len_used = N_W'(KEY_MAX);
        end
        else
        begin
            len_used = N_W'(key_length_reg);
        end
    end

    // Only the low HW bits of the hash reach the slot index, and those bits
    // depend on nothing above them, so the chain runs at slot-index width.
    assign lane_sel  = key_reg[idx_reg[LANE_W-1:0]];
    assign hash_sum  = hash_reg + lane_sel[HW-1:0];
    assign hash_prod = HW'(hash_sum * HASH_MUL_C);

    assign slot_epoch = slot_rd_data[SLOT_W-1:ID_W];
    assign slot_id    = slot_rd_data[ID_W-1:0];
    assign slot_hit   = (slot_epoch == epoch_reg);
    assign table_full = (fill_reg >= CNT_W'(CAP));
    assign insert_now = (state_reg == S_SLOT_CHK) && !slot_hit && ins_reg && !table_full;

    always_comb
    begin
        key_match = 1'b1;
        for (int i = 0; i < KEY_MAX; i++)
        begin
            if ((N_W'(i) < n_reg) && (key_rd[i] != key_reg[i]))
            begin
                key_match = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < KEY_MAX; i++)
        begin
            lane_we[i] = insert_now && (N_W'(i) < n_reg);
        end
    end

    always_comb
    begin
        if (state_reg == S_SWEEP)
        begin
            slot_we      = 1'b1;
            slot_wr_addr = sweep_reg;
            slot_wr_data = '0;
        end
        else
        begin
            slot_we      = insert_now;
            slot_wr_addr = probe_reg;
            slot_wr_data = {epoch_reg, fill_reg[ID_W-1:0]};
        end
    end

    assign slot_rd_addr = (state_reg == S_KEY_CHK) ? probe_reg + HW'(1) : probe_reg;

    always_comb
    begin
        state_next         = state_reg;
        key_length_next    = key_length_reg;
        fill_next          = fill_reg;
        epoch_next         = epoch_reg;
        sweep_next         = sweep_reg;
        sweep_pending_next = sweep_pending_reg;
        out_valid_next     = out_valid_reg;
        entry_id_next      = entry_id_reg;
        status_next        = status_reg;
        entry_count_next   = entry_count_reg;
        ins_next           = ins_reg;
        key_next           = key_reg;
        n_next             = n_reg;
        idx_next           = idx_reg;
        hash_next          = hash_reg;
        probe_next         = probe_reg;
        entry_next         = entry_reg;
        res_id_next        = res_id_reg;
        res_status_next    = res_status_reg;

        if (cfg_wr_en)
        begin
            key_length_next = cfg_wr_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_SWEEP:
            begin
                sweep_next = sweep_reg + HW'(1);
                if (sweep_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    for (int i = 0; i < KEY_MAX; i++)
                    begin
                        key_next[i] = key_in[i];
                    end
                    n_next    = len_used;
                    idx_next  = '0;
                    hash_next = '0;
                    unique case (lkht_pkg::command_t'(command))
                        lkht_pkg::CMD_CLEAR:
                        begin
                            fill_next       = '0;
                            res_id_next     = '0;
                            res_status_next = lkht_pkg::ST_CLEARED;
                            if (epoch_reg == '1)
                            begin
                                epoch_next         = EPOCH_FIRST;
                                sweep_pending_next = 1'b1;
                            end
                            else
                            begin
                                epoch_next = epoch_reg + EPOCH_FIRST;
                            end
                            state_next = S_DONE;
                        end
                        lkht_pkg::CMD_INSERT:
                        begin
                            ins_next   = 1'b1;
                            state_next = S_HASH;
                        end
                        default:
                        begin
                            ins_next   = 1'b0;
                            state_next = S_HASH;
                        end
                    endcase
                end
            end
            S_HASH:
            begin
                hash_next = hash_prod;
                idx_next  = idx_reg + N_W'(1);
                if ((idx_reg + N_W'(1)) == n_reg)
                begin
                    probe_next = hash_prod;
                    state_next = S_SLOT_RD;
                end
            end
            S_SLOT_RD:
            begin
                state_next = S_SLOT_CHK;
            end
            S_SLOT_CHK:
            begin
                entry_next = slot_id;
                if (slot_hit)
                begin
                    state_next = S_KEY_CHK;
                end
                else
                begin
                    res_id_next = '0;
                    if (!ins_reg)
                    begin
                        res_status_next = lkht_pkg::ST_ABSENT;
                    end
                    else if (table_full)
                    begin
                        res_status_next = lkht_pkg::ST_FULL;
                    end
                    else
                    begin
                        res_id_next     = fill_reg[ID_W-1:0];
                        res_status_next = lkht_pkg::ST_INSERTED;
                        fill_next       = fill_reg + CNT_W'(1);
                    end
                    state_next = S_DONE;
                end
            end
            S_KEY_CHK:
            begin
                if (key_match)
                begin
                    res_id_next     = entry_reg;
                    res_status_next = lkht_pkg::ST_FOUND;
                    state_next      = S_DONE;
                end
                else
                begin
                    probe_next = probe_reg + HW'(1);
                    state_next = S_SLOT_CHK;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next     = 1'b1;
                    entry_id_next      = res_id_reg;
                    status_next        = res_status_reg;
                    entry_count_next   = fill_reg;
                    sweep_pending_next = 1'b0;
                    state_next         = sweep_pending_reg ? S_SWEEP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_SWEEP;
            key_length_reg    <= lkht_pkg::KEY_LENGTH_RESET;
            fill_reg          <= '0;
            epoch_reg         <= EPOCH_FIRST;
            sweep_reg         <= '0;
            sweep_pending_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            entry_id_reg      <= '0;
            status_reg        <= lkht_pkg::ST_FOUND;
            entry_count_reg   <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            key_length_reg    <= key_length_next;
            fill_reg          <= fill_next;
            epoch_reg         <= epoch_next;
            sweep_reg         <= sweep_next;
            sweep_pending_reg <= sweep_pending_next;
            out_valid_reg     <= out_valid_next;
            entry_id_reg      <= entry_id_next;
            status_reg        <= status_next;
            entry_count_reg   <= entry_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_reg        <= ins_next;
        key_reg        <= key_next;
        n_reg          <= n_next;
        idx_reg        <= idx_next;
        hash_reg       <= hash_next;
        probe_reg      <= probe_next;
        entry_reg      <= entry_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
    end

    lkht_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_we),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data)
    );

    for (genvar g = 0; g < KEY_MAX; g++)
    begin : g_key_lane
        lkht_ram #(
            .WIDTH (lkht_pkg::KEY_W),
            .DEPTH (CAP)
        ) u_key_ram (
            .clk     (clk),
            .wr_en   (lane_we[g]),
            .wr_addr (fill_reg[ID_W-1:0]),
            .wr_data (key_reg[g]),
            .rd_addr (slot_id),
            .rd_data (key_rd[g])
        );
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign entry_id    = entry_id_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

endmodule

// ----- rtl/core/lkht_ram.sv -----
module lkht_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
